FILE: hw/rtl/ccst_pkg.sv
`default_nettype none

package ccst_pkg;

    // field widths
    localparam int KIND_W   = 1;
    localparam int CUR_W    = 16;
    localparam int VOLT_W   = 16;
    localparam int EL_W     = 24;
    localparam int LOAD_W   = 20;
    localparam int SOC_W    = 20;
    localparam int DIR_W    = 2;
    localparam int SECS_W   = 32;
    localparam int REST_W   = 27;

    // configuration register widths
    localparam int CAP_W    = 16;
    localparam int BAND_W   = 15;
    localparam int RTIME_W  = 26;
    localparam int FULLV_W  = 15;
    localparam int EMPTYV_W = 16;

    // apb port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    // serial multiply-divide unit
    localparam int MD_A_W       = 16;
    localparam int MD_B_W       = 24;
    localparam int MD_D_W       = 28;
    localparam int MD_P_W       = 40;
    localparam int MD_MUL_STEPS = MD_B_W;
    localparam int MD_DIV_STEPS = MD_P_W;

    // constants
    localparam logic [SOC_W-1:0]  SOC_FULL   = 20'd1000000;
    localparam logic [REST_W-1:0] REST_MAX   = 27'h7FFFFFF;
    localparam int                US_PER_S   = 1000000;
    localparam int                SEC_PER_HR = 3600;
    localparam int                SEC_ADD_W  = 5;
    localparam int                SEC_ADD_MAX = 16;

    // reset values
    localparam logic [CAP_W-1:0]    CAP_RST    = 16'd2000;
    localparam logic [BAND_W-1:0]   BAND_RST   = 15'd50;
    localparam logic [RTIME_W-1:0]  RTIME_RST  = 26'd60000000;
    localparam logic [FULLV_W-1:0]  FULLV_RST  = 15'd4180;
    localparam logic [EMPTYV_W-1:0] EMPTYV_RST = 16'd3000;

    typedef enum logic [DIR_W-1:0] {
        DIR_REST      = 2'd0,
        DIR_CHARGE    = 2'd1,
        DIR_DISCHARGE = 2'd2
    } dir_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK = 1'b0,
        KIND_LOAD = 1'b1
    } kind_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_CAPACITY = 3'd0,
        REG_BAND     = 3'd1,
        REG_RTIME    = 3'd2,
        REG_FULLV    = 3'd3,
        REG_EMPTYV   = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [CAP_W-1:0]    capacity_mah;
        logic [BAND_W-1:0]   rest_band_ma;
        logic [RTIME_W-1:0]  rest_time_us;
        logic [FULLV_W-1:0]  full_voltage_mv;
        logic [EMPTYV_W-1:0] empty_voltage_mv;
    } cfg_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ccst_if.sv
`default_nettype none

// measurement / load beat
interface ccst_in_if;
    logic                          valid;
    logic                          ready;
    logic [ccst_pkg::KIND_W-1:0]   kind;
    logic signed [ccst_pkg::CUR_W-1:0]  current_ma;
    logic signed [ccst_pkg::VOLT_W-1:0] voltage_mv;
    logic [ccst_pkg::EL_W-1:0]     elapsed_us;
    logic [ccst_pkg::LOAD_W-1:0]   soc_load;

    modport source (
        output valid, kind, current_ma, voltage_mv, elapsed_us, soc_load,
        input  ready
    );
    modport sink (
        input  valid, kind, current_ma, voltage_mv, elapsed_us, soc_load,
        output ready
    );
endinterface

// result beat
interface ccst_out_if;
    logic                          valid;
    logic                          ready;
    logic [ccst_pkg::SOC_W-1:0]    soc;
    logic [ccst_pkg::DIR_W-1:0]    charge_state;
    logic [ccst_pkg::SECS_W-1:0]   charge_seconds;
    logic [ccst_pkg::SOC_W-1:0]    pred_one_hour;
    logic [ccst_pkg::SOC_W-1:0]    pred_two_hour;
    logic                          recal_request;

    modport source (
        output valid, soc, charge_state, charge_seconds, pred_one_hour,
               pred_two_hour, recal_request,
        input  ready
    );
    modport sink (
        input  valid, soc, charge_state, charge_seconds, pred_one_hour,
               pred_two_hour, recal_request,
        output ready
    );
endinterface

`default_nettype wire

FILE: hw/rtl/ccst_apb_regs.sv
`default_nettype none

module ccst_apb_regs (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [ccst_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [ccst_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [ccst_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready,
    output ccst_pkg::cfg_t                         cfg
);

    ccst_pkg::cfg_t     cfg_reg;
    ccst_pkg::reg_idx_t idx;
    logic               wr_en;

    assign idx    = ccst_pkg::reg_idx_t'(paddr[ccst_pkg::APB_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.capacity_mah     <= ccst_pkg::CAP_RST;
            cfg_reg.rest_band_ma     <= ccst_pkg::BAND_RST;
            cfg_reg.rest_time_us     <= ccst_pkg::RTIME_RST;
            cfg_reg.full_voltage_mv  <= ccst_pkg::FULLV_RST;
            cfg_reg.empty_voltage_mv <= ccst_pkg::EMPTYV_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                ccst_pkg::REG_CAPACITY:
                    cfg_reg.capacity_mah     <= pwdata[ccst_pkg::CAP_W-1:0];
                ccst_pkg::REG_BAND:
                    cfg_reg.rest_band_ma     <= pwdata[ccst_pkg::BAND_W-1:0];
                ccst_pkg::REG_RTIME:
                    cfg_reg.rest_time_us     <= pwdata[ccst_pkg::RTIME_W-1:0];
                ccst_pkg::REG_FULLV:
                    cfg_reg.full_voltage_mv  <= pwdata[ccst_pkg::FULLV_W-1:0];
                ccst_pkg::REG_EMPTYV:
                    cfg_reg.empty_voltage_mv <= pwdata[ccst_pkg::EMPTYV_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (idx)
            ccst_pkg::REG_CAPACITY:
                prdata = ccst_pkg::APB_DATA_W'(cfg_reg.capacity_mah);
            ccst_pkg::REG_BAND:
                prdata = ccst_pkg::APB_DATA_W'(cfg_reg.rest_band_ma);
            ccst_pkg::REG_RTIME:
                prdata = ccst_pkg::APB_DATA_W'(cfg_reg.rest_time_us);
            ccst_pkg::REG_FULLV:
                prdata = ccst_pkg::APB_DATA_W'(cfg_reg.full_voltage_mv);
            ccst_pkg::REG_EMPTYV:
                prdata = ccst_pkg::APB_DATA_W'($signed(cfg_reg.empty_voltage_mv));
            default:
                prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/ccst_muldiv.sv
`default_nettype none

// bit-serial a*b/d: shift-add multiply one bit of b a cycle, then
// restoring divide one quotient bit a cycle in the same shift register
module ccst_muldiv (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [ccst_pkg::MD_A_W-1:0]   a,
    input  wire logic [ccst_pkg::MD_B_W-1:0]   b,
    input  wire logic [ccst_pkg::MD_D_W-1:0]   d,
    output logic                               done,
    output logic      [ccst_pkg::MD_P_W-1:0]   quo,
    output logic      [ccst_pkg::MD_D_W-1:0]   rem
);

    localparam int STEPS = ccst_pkg::MD_MUL_STEPS + ccst_pkg::MD_DIV_STEPS;
    localparam int CNT_W = $clog2(STEPS);
    localparam int HI_W  = ccst_pkg::MD_P_W - ccst_pkg::MD_B_W + 1;

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [ccst_pkg::MD_P_W:0]     acc_reg;
    logic [ccst_pkg::MD_A_W-1:0]   a_reg;
    logic [ccst_pkg::MD_D_W-1:0]   d_reg;
    logic [ccst_pkg::MD_D_W-1:0]   rem_reg;

    logic                          mul_phase;
    logic [HI_W-1:0]               hi_sum;
    logic [ccst_pkg::MD_P_W:0]     mul_next;
    logic [ccst_pkg::MD_D_W:0]     trial;
    logic [ccst_pkg::MD_D_W:0]     diff;
    logic                          ge;
    logic [ccst_pkg::MD_P_W:0]     div_next;
    logic [ccst_pkg::MD_D_W-1:0]   rem_step;

    assign mul_phase = cnt_reg < CNT_W'(ccst_pkg::MD_MUL_STEPS);

    // multiply step: add a into the high part when the low bit is set
    assign hi_sum   = acc_reg[ccst_pkg::MD_P_W:ccst_pkg::MD_B_W]
                    + (acc_reg[0] ? HI_W'(a_reg) : HI_W'(0));
    assign mul_next = {1'b0, hi_sum, acc_reg[ccst_pkg::MD_B_W-1:1]};

    // divide step: shift one dividend bit into the remainder
    assign trial    = {rem_reg, acc_reg[ccst_pkg::MD_P_W-1]};
    assign ge       = trial >= {1'b0, d_reg};
    assign diff     = trial - {1'b0, d_reg};
    assign rem_step = ge ? diff[ccst_pkg::MD_D_W-1:0] : trial[ccst_pkg::MD_D_W-1:0];
    assign div_next = {1'b0, acc_reg[ccst_pkg::MD_P_W-2:0], ge};

    // step control
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (busy_reg)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // shift datapath
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            if (mul_phase)
            begin
                acc_reg <= mul_next;
            end
            else
            begin
                acc_reg <= div_next;
                rem_reg <= rem_step;
            end
        end
        else if (start)
        begin
            a_reg   <= a;
            d_reg   <= d;
            acc_reg <= (ccst_pkg::MD_P_W + 1)'(b);
            rem_reg <= '0;
        end
    end

    assign done = done_reg;
    assign quo  = acc_reg[ccst_pkg::MD_P_W-1:0];
    assign rem  = rem_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/coulomb_counting_soc_tracker.sv
// path: a load beat or a rest tick passes the EVAL and DONE states into the output
// register; a charging or discharging tick runs INTEG and PRED between them, two
// 64-step passes of the bit-serial multiply-divide unit, I*t/(3600*cap) then I*1e6/cap
// throughput: one beat at a time; the next beat is taken once the result sits in the
// output register, even while that result still waits to be taken
// reset: asynchronous, active low; clears SOC and all tracking state, loads config defaults
`default_nettype none

module coulomb_counting_soc_tracker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [ccst_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [ccst_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [ccst_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready,
    ccst_in_if.sink                                in_ch,
    ccst_out_if.source                             out_ch
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_EVAL  = 5'b00010,
        ST_INTEG = 5'b00100,
        ST_PRED  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    localparam int DQ_W = ccst_pkg::MD_P_W + 1;

    // clamp soc +/- delta into 0..full
    function automatic logic [ccst_pkg::SOC_W-1:0] soc_adjust(
        input logic [ccst_pkg::SOC_W-1:0] base,
        input logic [DQ_W-1:0]            delta,
        input logic                       neg
    );
        logic [DQ_W-1:0]            base_x;
        logic [DQ_W-1:0]            room;
        logic [ccst_pkg::SOC_W-1:0] res;
        base_x = DQ_W'(base);
        room   = DQ_W'(ccst_pkg::SOC_FULL) - base_x;
        if (neg)
        begin
            res = (delta >= base_x) ? '0 : base - delta[ccst_pkg::SOC_W-1:0];
        end
        else
        begin
            res = (delta >= room) ? ccst_pkg::SOC_FULL : base + delta[ccst_pkg::SOC_W-1:0];
        end
        return res;
    endfunction

    // whole seconds in one tick, by parallel threshold compares
    function automatic logic [ccst_pkg::SEC_ADD_W-1:0] sec_count(
        input logic [ccst_pkg::EL_W-1:0] el
    );
        logic [ccst_pkg::SEC_ADD_W-1:0] n;
        n = '0;
        for (int k = 1; k <= ccst_pkg::SEC_ADD_MAX; k++)
        begin
            if (el >= ccst_pkg::EL_W'(k * ccst_pkg::US_PER_S))
            begin
                n = n + ccst_pkg::SEC_ADD_W'(1);
            end
        end
        return n;
    endfunction

    ccst_pkg::cfg_t cfg;

    // control and tracking state
    state_t                          state_reg, state_next;
    logic                            out_valid_reg, out_valid_next;
    logic [ccst_pkg::SOC_W-1:0]      soc_value_reg, soc_value_next;
    ccst_pkg::dir_t                  last_dir_reg, last_dir_next;
    logic [ccst_pkg::SECS_W-1:0]     dir_secs_reg, dir_secs_next;
    logic [ccst_pkg::REST_W-1:0]     rest_el_reg, rest_el_next;
    logic                            rest_started_reg, rest_started_next;

    // beat and working payload
    ccst_pkg::kind_t                 kind_reg;
    logic signed [ccst_pkg::CUR_W-1:0]  cur_reg;
    logic signed [ccst_pkg::VOLT_W-1:0] volt_reg;
    logic [ccst_pkg::EL_W-1:0]       el_reg;
    logic [ccst_pkg::LOAD_W-1:0]     load_reg;
    logic [ccst_pkg::SOC_W-1:0]      res_soc_reg;
    ccst_pkg::dir_t                  res_dir_reg;
    logic [ccst_pkg::SOC_W-1:0]      res_p1_reg;
    logic [ccst_pkg::SOC_W-1:0]      res_p2_reg;
    logic                            res_recal_reg;

    // output register
    logic [ccst_pkg::SOC_W-1:0]      out_soc_reg;
    logic [ccst_pkg::DIR_W-1:0]      out_dir_reg;
    logic [ccst_pkg::SECS_W-1:0]     out_secs_reg;
    logic [ccst_pkg::SOC_W-1:0]      out_p1_reg;
    logic [ccst_pkg::SOC_W-1:0]      out_p2_reg;
    logic                            out_recal_reg;

    // evaluation logic
    logic signed [ccst_pkg::CUR_W:0] cur_x;
    logic signed [ccst_pkg::CUR_W:0] band_x;
    logic signed [ccst_pkg::CUR_W:0] mag_x;
    logic [ccst_pkg::CUR_W-1:0]      mag;
    logic                            neg;
    ccst_pkg::dir_t                  dir;
    logic                            rest_zone;
    logic [ccst_pkg::SECS_W:0]       secs_sum;
    logic [ccst_pkg::SECS_W-1:0]     secs_eval;
    logic [ccst_pkg::REST_W:0]       rest_sum;
    logic [ccst_pkg::REST_W-1:0]     rest_eval;
    logic                            recal_eval;
    logic                            full_hit;
    logic                            empty_hit;
    logic [ccst_pkg::SOC_W-1:0]      soc_base;
    logic [ccst_pkg::SOC_W-1:0]      load_sat;
    logic [ccst_pkg::CAP_W-1:0]      cap_eff;
    logic [ccst_pkg::MD_D_W-1:0]     cap_hr;

    // multiply-divide unit hookup
    logic                            md_start;
    logic [ccst_pkg::MD_B_W-1:0]     md_b;
    logic [ccst_pkg::MD_D_W-1:0]     md_d;
    logic                            md_done;
    logic [ccst_pkg::MD_P_W-1:0]     md_quo;
    logic [ccst_pkg::MD_D_W-1:0]     md_rem;
    logic [DQ_W-1:0]                 q_one;
    logic [DQ_W-1:0]                 q_two;
    logic                            rem_half;
    logic [ccst_pkg::SOC_W-1:0]      soc_integ;
    logic [ccst_pkg::SOC_W-1:0]      pred_one;
    logic [ccst_pkg::SOC_W-1:0]      pred_two;

    logic                            in_fire;
    logic                            out_load;

    ccst_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ccst_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (md_start),
        .a     (mag),
        .b     (md_b),
        .d     (md_d),
        .done  (md_done),
        .quo   (md_quo),
        .rem   (md_rem)
    );

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign out_load    = (state_reg == ST_DONE) && (!out_valid_reg || out_ch.ready);

    // current classification
    assign cur_x     = (ccst_pkg::CUR_W + 1)'(cur_reg);
    assign band_x    = $signed({2'b00, cfg.rest_band_ma});
    assign mag_x     = cur_reg[ccst_pkg::CUR_W-1] ? -cur_x : cur_x;
    assign mag       = mag_x[ccst_pkg::CUR_W-1:0];
    assign neg       = cur_reg[ccst_pkg::CUR_W-1];
    assign rest_zone = mag < {1'b0, cfg.rest_band_ma};

    always_comb
    begin
        priority if (cur_x > band_x)
        begin
            dir = ccst_pkg::DIR_CHARGE;
        end
        else if (cur_x < -band_x)
        begin
            dir = ccst_pkg::DIR_DISCHARGE;
        end
        else
        begin
            dir = ccst_pkg::DIR_REST;
        end
    end

    // direction seconds, saturating
    assign secs_sum = {1'b0, dir_secs_reg} + (ccst_pkg::SECS_W + 1)'(sec_count(el_reg));
    always_comb
    begin
        priority if (dir == ccst_pkg::DIR_REST)
        begin
            secs_eval = dir_secs_reg;
        end
        else if (dir != last_dir_reg)
        begin
            secs_eval = '0;
        end
        else
        begin
            secs_eval = secs_sum[ccst_pkg::SECS_W] ? '1 : secs_sum[ccst_pkg::SECS_W-1:0];
        end
    end

    // rest timer, saturating
    assign rest_sum = {1'b0, rest_el_reg} + (ccst_pkg::REST_W + 1)'(el_reg);
    always_comb
    begin
        priority if (!rest_zone)
        begin
            rest_eval = '0;
        end
        else if (!rest_started_reg)
        begin
            rest_eval = '0;
        end
        else
        begin
            rest_eval = rest_sum[ccst_pkg::REST_W] ? ccst_pkg::REST_MAX
                                                   : rest_sum[ccst_pkg::REST_W-1:0];
        end
    end
    assign recal_eval = rest_zone && (rest_eval > ccst_pkg::REST_W'(cfg.rest_time_us));

    // full and empty forcing
    assign full_hit  = rest_zone && (volt_reg >= $signed({1'b0, cfg.full_voltage_mv}));
    assign empty_hit = volt_reg <= $signed(cfg.empty_voltage_mv);
    always_comb
    begin
        priority if (empty_hit)
        begin
            soc_base = '0;
        end
        else if (full_hit)
        begin
            soc_base = ccst_pkg::SOC_FULL;
        end
        else
        begin
            soc_base = soc_value_reg;
        end
    end

    assign load_sat = (load_reg > ccst_pkg::SOC_FULL) ? ccst_pkg::SOC_FULL : load_reg;

    // divisors
    assign cap_eff = (cfg.capacity_mah == '0) ? ccst_pkg::CAP_W'(1) : cfg.capacity_mah;
    assign cap_hr  = ccst_pkg::MD_D_W'(cap_eff) * ccst_pkg::MD_D_W'(ccst_pkg::SEC_PER_HR);

    // first pass I*t/(3600*cap), second pass I*1e6/cap
    assign md_start = ((state_reg == ST_EVAL) && (kind_reg == ccst_pkg::KIND_TICK)
                       && (dir != ccst_pkg::DIR_REST))
                   || ((state_reg == ST_INTEG) && md_done);
    assign md_b     = (state_reg == ST_EVAL) ? el_reg : ccst_pkg::MD_B_W'(ccst_pkg::US_PER_S);
    assign md_d     = (state_reg == ST_EVAL) ? cap_hr : ccst_pkg::MD_D_W'(cap_eff);

    // two-hour quotient from the one-hour quotient and remainder
    assign q_one     = DQ_W'(md_quo);
    assign rem_half  = {md_rem, 1'b0} >= (ccst_pkg::MD_D_W + 1)'(cap_eff);
    assign q_two     = {md_quo, rem_half};
    assign soc_integ = soc_adjust(res_soc_reg, q_one, neg);
    assign pred_one  = soc_adjust(res_soc_reg, q_one, neg);
    assign pred_two  = soc_adjust(res_soc_reg, q_two, neg);

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        soc_value_next    = soc_value_reg;
        last_dir_next     = last_dir_reg;
        dir_secs_next     = dir_secs_reg;
        rest_el_next      = rest_el_reg;
        rest_started_next = rest_started_reg;
        out_valid_next    = out_valid_reg && !out_ch.ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (kind_reg == ccst_pkg::KIND_LOAD)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    dir_secs_next     = secs_eval;
                    rest_el_next      = rest_eval;
                    rest_started_next = rest_zone;
                    if (dir != ccst_pkg::DIR_REST)
                    begin
                        last_dir_next = dir;
                        state_next    = ST_INTEG;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_INTEG:
            begin
                if (md_done)
                begin
                    state_next = ST_PRED;
                end
            end
            ST_PRED:
            begin
                if (md_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    soc_value_next = res_soc_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            out_valid_reg    <= 1'b0;
            soc_value_reg    <= '0;
            last_dir_reg     <= ccst_pkg::DIR_REST;
            dir_secs_reg     <= '0;
            rest_el_reg      <= '0;
            rest_started_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            out_valid_reg    <= out_valid_next;
            soc_value_reg    <= soc_value_next;
            last_dir_reg     <= last_dir_next;
            dir_secs_reg     <= dir_secs_next;
            rest_el_reg      <= rest_el_next;
            rest_started_reg <= rest_started_next;
        end
    end

    // beat capture and working results
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            kind_reg <= ccst_pkg::kind_t'(in_ch.kind);
            cur_reg  <= in_ch.current_ma;
            volt_reg <= in_ch.voltage_mv;
            el_reg   <= in_ch.elapsed_us;
            load_reg <= in_ch.soc_load;
        end

        if (state_reg == ST_EVAL)
        begin
            if (kind_reg == ccst_pkg::KIND_LOAD)
            begin
                res_soc_reg   <= load_sat;
                res_dir_reg   <= ccst_pkg::DIR_REST;
                res_p1_reg    <= load_sat;
                res_p2_reg    <= load_sat;
                res_recal_reg <= 1'b0;
            end
            else
            begin
                res_soc_reg   <= soc_base;
                res_dir_reg   <= dir;
                res_p1_reg    <= soc_base;
                res_p2_reg    <= soc_base;
                res_recal_reg <= recal_eval;
            end
        end

        if ((state_reg == ST_INTEG) && md_done)
        begin
            res_soc_reg <= soc_integ;
        end

        if ((state_reg == ST_PRED) && md_done)
        begin
            res_p1_reg <= pred_one;
            res_p2_reg <= pred_two;
        end

        if (out_load)
        begin
            out_soc_reg   <= res_soc_reg;
            out_dir_reg   <= res_dir_reg;
            out_secs_reg  <= dir_secs_reg;
            out_p1_reg    <= res_p1_reg;
            out_p2_reg    <= res_p2_reg;
            out_recal_reg <= res_recal_reg;
        end
    end

    // result beat
    assign out_ch.valid          = out_valid_reg;
    assign out_ch.soc            = out_soc_reg;
    assign out_ch.charge_state   = out_dir_reg;
    assign out_ch.charge_seconds = out_secs_reg;
    assign out_ch.pred_one_hour  = out_p1_reg;
    assign out_ch.pred_two_hour  = out_p2_reg;
    assign out_ch.recal_request  = out_recal_reg;

endmodule

`default_nettype wire

FILE: dv/soc_tracker_checker.sv
`timescale 1ns / 100ps

module soc_tracker_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic                              pready,
    input  wire logic [ccst_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [ccst_pkg::APB_DATA_W-1:0]   pwdata,
    ccst_in_if                                     in_ch,
    ccst_out_if                                    out_ch,
    output int                                     fails,
    output int                                     pending
);

    import ccst_pkg::*;

    localparam longint SOC_MAX    = longint'(SOC_FULL);
    localparam longint REST_LIMIT = longint'(REST_MAX);
    localparam longint SECS_MAX   = 64'hFFFF_FFFF;

    // one predicted result beat
    typedef struct packed {
        logic [SOC_W-1:0]  soc;
        dir_t              charge_state;
        logic [SECS_W-1:0] charge_seconds;
        logic [SOC_W-1:0]  pred_one_hour;
        logic [SOC_W-1:0]  pred_two_hour;
        logic              recal_request;
    } soc_reading_t;

    cfg_t              cfg;
    logic [SOC_W-1:0]  soc_now;
    dir_t              last_dir;
    logic [SECS_W-1:0] dir_secs;
    logic [REST_W-1:0] rest_us;
    logic              resting;
    soc_reading_t      pending_readings[$];
    soc_reading_t      want;

    function automatic longint clamp_soc(input longint v);
        if (v > SOC_MAX)
            return SOC_MAX;
        if (v < 0)
            return 0;
        return v;
    endfunction

    // advance the tracked battery state by one beat and return the reading it gives
    function automatic soc_reading_t next_reading(
        input kind_t                     kind,
        input logic signed [CUR_W-1:0]   cur,
        input logic signed [VOLT_W-1:0]  volt,
        input logic [EL_W-1:0]           el,
        input logic [LOAD_W-1:0]         load
    );
        soc_reading_t r;
        longint       c;
        longint       v;
        longint       e;
        longint       mag;
        longint       band;
        longint       cap;
        longint       full;
        longint       empty;
        longint       soc;
        dir_t         dir;

        c     = cur;
        v     = volt;
        e     = el;
        mag   = (c < 0) ? -c : c;
        band  = cfg.rest_band_ma;
        full  = cfg.full_voltage_mv;
        empty = $signed(cfg.empty_voltage_mv);
        cap   = (cfg.capacity_mah == '0) ? 1 : cfg.capacity_mah;

        // load beat: only the soc changes
        if (kind == KIND_LOAD)
        begin
            soc_now = (load > SOC_FULL) ? SOC_FULL : load;
            r.soc            = soc_now;
            r.charge_state   = DIR_REST;
            r.charge_seconds = dir_secs;
            r.pred_one_hour  = soc_now;
            r.pred_two_hour  = soc_now;
            r.recal_request  = 1'b0;
            return r;
        end

        if (c > band)
            dir = DIR_CHARGE;
        else if (c < -band)
            dir = DIR_DISCHARGE;
        else
            dir = DIR_REST;

        // new direction restarts the seconds count, rest holds it
        if (dir != DIR_REST)
        begin
            if (dir != last_dir)
                dir_secs = '0;
            else if (longint'(dir_secs) + e / US_PER_S > SECS_MAX)
                dir_secs = '1;
            else
                dir_secs = dir_secs + SECS_W'(e / US_PER_S);
            last_dir = dir;
        end

        soc = soc_now;
        r.recal_request = 1'b0;

        // rest timing and full check only strictly inside the band
        if (mag < band)
        begin
            if (!resting)
            begin
                resting = 1'b1;
                rest_us = '0;
            end
            else if (longint'(rest_us) + e > REST_LIMIT)
                rest_us = REST_MAX;
            else
                rest_us = rest_us + REST_W'(e);
            if (rest_us > cfg.rest_time_us)
                r.recal_request = 1'b1;
            if (v >= full)
                soc = SOC_MAX;
        end
        else
        begin
            resting = 1'b0;
            rest_us = '0;
        end
        if (v <= empty)
            soc = 0;

        // coulomb integration, truncated toward zero
        if (mag > band)
            soc = soc + (c * e) / (SEC_PER_HR * cap);
        soc     = clamp_soc(soc);
        soc_now = SOC_W'(soc);

        r.soc            = soc_now;
        r.charge_state   = dir;
        r.charge_seconds = dir_secs;
        if (dir == DIR_REST)
        begin
            r.pred_one_hour = soc_now;
            r.pred_two_hour = soc_now;
        end
        else
        begin
            r.pred_one_hour = SOC_W'(clamp_soc(soc + (c * US_PER_S) / cap));
            r.pred_two_hour = SOC_W'(clamp_soc(soc + (c * 2 * US_PER_S) / cap));
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint exp_val);
        $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, exp_val);
        fails++;
    endtask

    // watch config writes, input beats and result beats
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg.capacity_mah     = CAP_RST;
            cfg.rest_band_ma     = BAND_RST;
            cfg.rest_time_us     = RTIME_RST;
            cfg.full_voltage_mv  = FULLV_RST;
            cfg.empty_voltage_mv = EMPTYV_RST;
            soc_now  = '0;
            last_dir = DIR_REST;
            dir_secs = '0;
            rest_us  = '0;
            resting  = 1'b0;
            pending_readings.delete();
            fails    = 0;
            pending  = 0;
        end
        else
        begin
            // register write, unmapped indexes fall through
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[APB_ADDR_W-1:2]))
                    REG_CAPACITY: cfg.capacity_mah     = pwdata[CAP_W-1:0];
                    REG_BAND:     cfg.rest_band_ma     = pwdata[BAND_W-1:0];
                    REG_RTIME:    cfg.rest_time_us     = pwdata[RTIME_W-1:0];
                    REG_FULLV:    cfg.full_voltage_mv  = pwdata[FULLV_W-1:0];
                    REG_EMPTYV:   cfg.empty_voltage_mv = pwdata[EMPTYV_W-1:0];
                    default:      ;
                endcase
            end

            // input beat
            if (in_ch.valid && in_ch.ready)
                pending_readings.push_back(next_reading(kind_t'(in_ch.kind), in_ch.current_ma,
                    in_ch.voltage_mv, in_ch.elapsed_us, in_ch.soc_load));

            // result beat against the oldest prediction
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_readings.size() == 0)
                    report_mismatch("unexpected result beat, soc", out_ch.soc, 0);
                else
                begin
                    want = pending_readings.pop_front();
                    if (out_ch.soc !== want.soc)
                        report_mismatch("soc", out_ch.soc, want.soc);
                    if (out_ch.charge_state !== want.charge_state)
                        report_mismatch("charge_state", out_ch.charge_state, want.charge_state);
                    if (out_ch.charge_seconds !== want.charge_seconds)
                        report_mismatch("charge_seconds", out_ch.charge_seconds,
                            want.charge_seconds);
                    if (out_ch.pred_one_hour !== want.pred_one_hour)
                        report_mismatch("pred_one_hour", out_ch.pred_one_hour,
                            want.pred_one_hour);
                    if (out_ch.pred_two_hour !== want.pred_two_hour)
                        report_mismatch("pred_two_hour", out_ch.pred_two_hour,
                            want.pred_two_hour);
                    if (out_ch.recal_request !== want.recal_request)
                        report_mismatch("recal_request", out_ch.recal_request,
                            want.recal_request);
                end
            end
            pending = pending_readings.size();
        end
    end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;

    import ccst_pkg::*;

    // stall-free stretch bound: long receiver hold-off plus two divider passes, with margin
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 200;
    localparam int CUR_TOP        = 2 ** (CUR_W - 1) - 1;
    localparam int CUR_BOT        = -(2 ** (CUR_W - 1));
    localparam logic [REG_IDX_W-1:0] REG_SPARE = 3'd7;

    typedef enum int {
        RUN_REST,
        RUN_CHARGE,
        RUN_DISCHARGE
    } run_kind_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    int                    fails;
    int                    pending;
    int                    idle_cycles;
    int                    band_now;
    int                    full_now;
    int                    empty_now;
    logic                  calm;
    logic                  stall_pending;

    ccst_in_if  in_ch ();
    ccst_out_if out_ch ();

    coulomb_counting_soc_tracker u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    soc_tracker_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .pready  (pready),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .fails   (fails),
        .pending (pending)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // watchdog on cycles without any accepted beat or register access
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (psel && penable))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL coulomb_counting_soc_tracker");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // result receiver with random back-pressure and one long hold-off
    initial
    begin
        logic held;
        held         = 1'b0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_pending && !held)
            begin
                held = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_ch.ready <= calm || ($urandom_range(99) >= 22);
        end
    end

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input int cap, input int band, input int rtime, input int full,
                              input int empty);
        write_reg(REG_CAPACITY, cap);
        write_reg(REG_BAND, band);
        write_reg(REG_RTIME, rtime);
        write_reg(REG_FULLV, full);
        write_reg(REG_EMPTYV, empty);
        band_now  = band;
        full_now  = full;
        empty_now = empty;
    endtask

    // offer one beat, with random gaps before it, and wait until it is taken
    task automatic send_beat(input kind_t kind, input logic signed [CUR_W-1:0] cur,
                             input logic signed [VOLT_W-1:0] volt,
                             input logic [EL_W-1:0] el, input logic [LOAD_W-1:0] load);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 22)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.kind       <= kind;
        in_ch.current_ma <= cur;
        in_ch.voltage_mv <= volt;
        in_ch.elapsed_us <= el;
        in_ch.soc_load   <= load;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // current for the present run: inside the band, on its edge, or beyond it
    function automatic logic signed [CUR_W-1:0] pick_current(input run_kind_t regime);
        int mag;
        if (regime == RUN_REST)
            mag = ($urandom_range(9) == 0) ? band_now : int'($urandom_range(band_now));
        else if ($urandom_range(9) == 0)
            mag = band_now + int'($urandom_range(1));
        else
            mag = band_now + 1 + int'($urandom_range(3000));
        // rest currents take either sign
        if (regime == RUN_DISCHARGE || (regime == RUN_REST && $urandom_range(1) == 1))
            return CUR_W'((mag > -CUR_BOT) ? CUR_BOT : -mag);
        return CUR_W'((mag > CUR_TOP) ? CUR_TOP : mag);
    endfunction

    // mostly a realistic cell voltage, sometimes around the full and empty thresholds
    function automatic logic signed [VOLT_W-1:0] pick_voltage();
        int v;
        case ($urandom_range(9))
            0:       v = full_now + int'($urandom_range(200));
            1:       v = empty_now - int'($urandom_range(200));
            2:       return VOLT_W'($urandom);
            default: v = int'($urandom_range(4300, 2800));
        endcase
        if (v > CUR_TOP)
            v = CUR_TOP;
        if (v < CUR_BOT)
            v = CUR_BOT;
        return VOLT_W'(v);
    endfunction

    function automatic logic [EL_W-1:0] pick_elapsed();
        case ($urandom_range(9))
            0:       return EL_W'($urandom);
            1:       return EL_W'($urandom_range(US_PER_S - 1));
            2:       return '1;
            default: return EL_W'($urandom_range(2500000, 500000));
        endcase
    endfunction

    // runs of rest, charge or discharge ticks with loads and noise mixed in
    task automatic run_random(input int count);
        run_kind_t             regime;
        int                    left;
        logic signed [CUR_W-1:0] cur;
        logic [LOAD_W-1:0]     load;
        left   = 0;
        regime = RUN_REST;
        for (int i = 0; i < count; i++)
        begin
            if (left == 0)
            begin
                regime = run_kind_t'($urandom_range(2));
                left   = $urandom_range(40, 4);
            end
            left--;
            if ($urandom_range(99) < 6)
            begin
                load = ($urandom_range(3) == 0) ? LOAD_W'($urandom)
                                                : LOAD_W'($urandom_range(SOC_FULL));
                send_beat(KIND_LOAD, CUR_W'($urandom), VOLT_W'($urandom), EL_W'($urandom),
                          load);
            end
            else
            begin
                cur = ($urandom_range(99) < 8) ? CUR_W'($urandom) : pick_current(regime);
                send_beat(KIND_TICK, cur, pick_voltage(), pick_elapsed(), LOAD_W'($urandom));
            end
        end
    endtask

    // stimulus and verdict
    initial
    begin
        rst_n               = 1'b0;
        calm                = 1'b0;
        stall_pending       = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        in_ch.valid         = 1'b0;
        in_ch.kind          = KIND_TICK;
        in_ch.current_ma    = '0;
        in_ch.voltage_mv    = '0;
        in_ch.elapsed_us    = '0;
        in_ch.soc_load      = '0;
        band_now            = BAND_RST;
        full_now            = FULLV_RST;
        empty_now           = $signed(EMPTYV_RST);
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // loads: saturation, zero, midpoint
        send_beat(KIND_LOAD, CUR_W'($urandom), VOLT_W'($urandom), EL_W'($urandom), '1);
        send_beat(KIND_LOAD, CUR_W'($urandom), VOLT_W'($urandom), EL_W'($urandom), '0);
        send_beat(KIND_LOAD, 0, 0, 0, 500000);
        // first rest tick starts the timer, long rest raises recal and saturates
        send_beat(KIND_TICK, 0, 3700, EL_W'(US_PER_S), 0);
        for (int i = 0; i < 9; i++)
            send_beat(KIND_TICK, (i % 2 == 0) ? 10 : -10, 3700, '1, 0);
        send_beat(KIND_TICK, 0, 4180, '1, 0);
        // magnitude equal to the band: rest state but no rest timing or full check
        send_beat(KIND_TICK, 50, 4180, '1, 0);
        send_beat(KIND_TICK, -50, 3000, '1, 0);
        // first charge direction, then extremes and a direction change
        send_beat(KIND_TICK, 51, 3700, 3000000, 0);
        send_beat(KIND_TICK, CUR_W'(CUR_TOP), 3700, '1, 0);
        send_beat(KIND_LOAD, 0, 0, 0, 999999);
        send_beat(KIND_TICK, CUR_W'(CUR_BOT), VOLT_W'(CUR_BOT), '1, 0);
        send_beat(KIND_TICK, -51, VOLT_W'(CUR_TOP), 0, 0);
        send_beat(KIND_TICK, 0, VOLT_W'(CUR_TOP), 0, 0);

        // reset settings, with one long receiver hold-off and a gap-free stretch
        run_random(120);
        stall_pending = 1'b1;
        run_random(60);
        calm = 1'b1;
        run_random(80);
        calm = 1'b0;
        run_random(40);
        wait_for_results();

        // low extremes
        set_config(1, 0, 0, 0, CUR_BOT);
        run_random(150);
        wait_for_results();

        // high extremes
        set_config(65535, 32767, 67108863, 32767, CUR_TOP);
        run_random(150);
        wait_for_results();

        // zero capacity acts as one
        set_config(0, 20, 0, 4100, 3100);
        run_random(200);
        wait_for_results();

        // unmapped register is ignored
        write_reg(REG_SPARE, '1);
        set_config(3000, 100, 5000000, 4150, 2900);
        run_random(300);
        wait_for_results();

        set_config($urandom_range(65535), $urandom_range(400), $urandom_range(20000000),
                   $urandom_range(4300, 3500), $urandom_range(3400, 2500));
        run_random(250);
        wait_for_results();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fails == 0 && pending == 0)
            $display("PASS coulomb_counting_soc_tracker");
        else
            $display("FAIL coulomb_counting_soc_tracker");
        $finish;
    end

endmodule

FILE: coulomb_counting_soc_tracker.f
hw/rtl/ccst_pkg.sv
hw/rtl/ccst_if.sv
hw/rtl/ccst_apb_regs.sv
hw/rtl/ccst_muldiv.sv
hw/rtl/coulomb_counting_soc_tracker.sv
dv/soc_tracker_checker.sv
dv/testbench.sv
